// ===== design/pts_pkg.sv =====
`timescale 1ns / 1ps

package pts_pkg;

	localparam logic signed [11:0] SEL_THRESHOLD = 12'sd200;
	localparam logic [7:0]         TICK_UNIT     = 8'd195;
	localparam logic [6:0]         BLEND_FULL    = 7'd100;
	localparam logic [6:0]         BLEND_TOP     = 7'd99;

	typedef enum logic [2:0] {
		PH_P1   = 3'd0,
		PH_P2   = 3'd1,
		PH_RAMP = 3'd2,
		PH_UP   = 3'd3,
		PH_DOWN = 3'd4
	} phase_t;

	typedef struct packed {
		logic [7:0]         elapsed_ticks;
		logic signed [11:0] mode_channel;
	} in_t;

	typedef struct packed {
		logic [6:0] blend_count;
		logic [2:0] phase;
		logic       profile_select;
	} out_t;

	typedef struct packed {
		phase_t      phase;
		logic [6:0]  blend;
		logic        first_pass;
		logic        prev_select;
		logic [3:0]  prev_speed;
		logic        ramp_down;
		logic [15:0] step_timer;
		logic [7:0]  prev_quantized;
	} state_t;

endpackage

// ===== design/pts_step_logic.sv =====
`timescale 1ns / 1ps

module pts_step_logic (
	input  pts_pkg::state_t state_q,
	input  pts_pkg::in_t    item,
	input  logic [3:0]      ramp_speed,
	output pts_pkg::state_t state_d,
	output pts_pkg::out_t   res
);
	import pts_pkg::*;

	logic        sel;
	logic [7:0]  qbits;
	logic        timed;
	logic        req;
	logic        step;
	logic [11:0] limit;
	logic [15:0] timer_sum;
	phase_t      ph;
	logic [6:0]  blend;
	logic        psel;
	logic        down;

	assign limit = 12'(ramp_speed) * 12'(TICK_UNIT);

	always_comb begin
		sel       = (item.mode_channel > SEL_THRESHOLD);
		// An arithmetic shift right by four keeps just the top eight bits.
		qbits     = item.mode_channel[11:4];
		timed     = (ramp_speed != 4'd0);
		timer_sum = state_q.step_timer + 16'(item.elapsed_ticks);

		ph    = state_q.phase;
		blend = state_q.blend;
		psel  = state_q.prev_select;
		down  = state_q.ramp_down;

		if (state_q.first_pass || (state_q.prev_speed != ramp_speed)) begin
			ph    = sel ? PH_P2 : PH_P1;
			blend = sel ? BLEND_FULL : 7'd0;
			psel  = sel;
		end

		req = (timed && (sel != psel)) || (!timed && (state_q.prev_quantized != qbits));

		if (req) begin
			if (!timed) begin
				ph = PH_RAMP;
			end else if (sel && !psel) begin
				ph = PH_UP;
			end else if (!sel && psel) begin
				ph = PH_DOWN;
			end
		end

		step = (timed && (timer_sum > 16'(limit))) || req;

		state_d                = state_q;
		state_d.step_timer     = step ? 16'd0 : timer_sum;
		state_d.first_pass     = 1'b0;
		state_d.prev_speed     = ramp_speed;
		state_d.prev_select    = sel;
		state_d.prev_quantized = qbits;

		if (step) begin
			case (ph)
				PH_P1: begin
					blend = 7'd0;
				end
				PH_P2: begin
					blend = BLEND_FULL;
				end
				PH_RAMP, PH_UP, PH_DOWN: begin
					if (ph != PH_RAMP) begin
						down = (ph == PH_DOWN);
					end
					ph = PH_RAMP;
					if (down) begin
						if (blend <= 7'd1) begin
							blend = 7'd0;
							ph    = PH_P1;
						end else begin
							blend = blend - 7'd1;
						end
					end else begin
						if ((blend + 7'd1) >= BLEND_TOP) begin
							blend = BLEND_TOP;
							ph    = PH_P2;
						end else begin
							blend = blend + 7'd1;
						end
					end
				end
				default: begin
				end
			endcase
		end

		state_d.phase     = ph;
		state_d.blend     = blend;
		state_d.ramp_down = down;

		res.blend_count    = blend;
		res.phase          = ph;
		res.profile_select = sel;
	end

endmodule

// ===== design/profile_transition_sequencer.sv =====
`timescale 1ns / 1ps
// Channel   Handshake             Payload
// item      item_valid/stall      pts_pkg::in_t  (elapsed_ticks, mode_channel)
// result    result_valid/stall    pts_pkg::out_t (blend_count, phase, profile_select)
// cfg       cfg_valid/ready       cfg_data, ramp_speed (4 bits)
//
// One item per cycle is sustained while the result is not stalled; each item goes from
// its input beat to its result beat through the input register and the result register.
// The state update of a pass is combinational logic between those registers.
// Reset clears the sequencer state, the configuration and both valid flags.
// A stalled result holds the input register, which then stalls the item channel.

module profile_transition_sequencer (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	output logic           item_stall,
	input  pts_pkg::in_t   item,
	output logic           result_valid,
	input  logic           result_stall,
	output pts_pkg::out_t  result,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic [3:0]     cfg_data
);
	import pts_pkg::*;

	in_t        item_s1;
	logic       valid_s1;
	out_t       result_q;
	logic       result_valid_q;
	logic [3:0] ramp_speed_q;
	state_t     state_q;
	state_t     state_d;
	out_t       res;
	logic       advance;

	assign advance      = valid_s1 && (!result_valid_q || !result_stall);
	assign item_stall   = valid_s1 && !advance;
	assign cfg_ready    = 1'b1;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	pts_step_logic u_step (
		.state_q    (state_q),
		.item       (item_s1),
		.ramp_speed (ramp_speed_q),
		.state_d    (state_d),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			result_valid_q <= 1'b0;
			ramp_speed_q   <= 4'd0;
			state_q.phase          <= PH_P1;
			state_q.blend          <= 7'd0;
			state_q.first_pass     <= 1'b1;
			state_q.prev_select    <= 1'b0;
			state_q.prev_speed     <= 4'd0;
			state_q.ramp_down      <= 1'b0;
			state_q.step_timer     <= 16'd0;
			state_q.prev_quantized <= 8'd0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				ramp_speed_q <= cfg_data;
			end
			if (item_valid && !item_stall) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				result_valid_q <= 1'b1;
				state_q        <= state_d;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
		if (advance) begin
			result_q <= res;
		end
	end

endmodule

// ===== bench/profile_transition_sequencer_test.sv =====
`timescale 1ns / 1ps

module profile_transition_sequencer_test;
	import pts_pkg::*;

	localparam int QUIET_LIMIT   = 2000;
	localparam int RANDOM_PASSES = 470;
	localparam int HOLD_PASSES   = 270;
	localparam int SHOWN_ERRORS  = 30;

	logic  clk          = 1'b0;
	logic  arst_n       = 1'b0;
	logic  item_valid   = 1'b0;
	logic  item_stall;
	in_t   item         = '0;
	logic  result_valid;
	logic  result_stall = 1'b0;
	out_t  result;
	logic  cfg_valid    = 1'b0;
	logic  cfg_ready;
	logic  [3:0] cfg_data = 4'd0;

	profile_transition_sequencer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Own copy of the sequencer state, advanced once per accepted pass.
	logic [3:0]  speed_setting = 4'd0;
	phase_t      seq_phase     = PH_P1;
	logic [6:0]  seq_blend     = 7'd0;
	logic        seq_first     = 1'b1;
	logic        seq_prev_sel  = 1'b0;
	logic [3:0]  seq_prev_spd  = 4'd0;
	logic        seq_down      = 1'b0;
	logic [15:0] seq_timer     = 16'd0;
	logic [7:0]  seq_prev_q    = 8'd0;

	out_t predicted_blends[$];

	int errors          = 0;
	int passes_sent     = 0;
	int speed_writes    = 0;
	int results_checked = 0;
	int quiet_cycles    = 0;
	int stall_left      = 0;
	bit steady_source   = 1'b0;
	bit steady_sink     = 1'b0;

	function automatic out_t advance_sequencer(logic [7:0] ticks, logic signed [11:0] ch);
		logic       sel;
		logic [7:0] qbits;
		logic       bump;
		int         limit_ticks;
		int         b;
		out_t       o;
		sel   = (ch > SEL_THRESHOLD);
		qbits = ch[11:4];
		if (seq_first || seq_prev_spd != speed_setting) begin
			seq_phase    = sel ? PH_P2 : PH_P1;
			seq_blend    = sel ? BLEND_FULL : 7'd0;
			seq_prev_sel = sel;
			seq_prev_spd = speed_setting;
			seq_first    = 1'b0;
		end
		bump = (speed_setting != 0 && sel != seq_prev_sel) ||
			(speed_setting == 0 && seq_prev_q != qbits);
		seq_timer  = seq_timer + 16'(ticks);
		seq_prev_q = qbits;
		if (bump) begin
			if (speed_setting == 0) begin
				seq_phase = PH_RAMP;
			end else if (sel && !seq_prev_sel) begin
				seq_phase    = PH_UP;
				seq_prev_sel = 1'b1;
			end else if (!sel && seq_prev_sel) begin
				seq_phase    = PH_DOWN;
				seq_prev_sel = 1'b0;
			end
		end
		limit_ticks = int'(TICK_UNIT) * int'(speed_setting);
		if ((speed_setting != 0 && int'(seq_timer) > limit_ticks) || bump) begin
			seq_timer = 16'd0;
			case (seq_phase)
				PH_P1: seq_blend = 7'd0;
				PH_P2: seq_blend = BLEND_FULL;
				PH_RAMP, PH_UP, PH_DOWN: begin
					// A starting phase latches the direction, then ramps like any other step.
					if (seq_phase != PH_RAMP) begin
						seq_down  = (seq_phase == PH_DOWN);
						seq_phase = PH_RAMP;
					end
					b = int'(seq_blend);
					if (seq_down) begin
						b = b - 1;
						if (b <= 0) begin
							b         = 0;
							seq_phase = PH_P1;
						end
					end else begin
						b = b + 1;
						if (b >= int'(BLEND_TOP)) begin
							b         = int'(BLEND_TOP);
							seq_phase = PH_P2;
						end
					end
					seq_blend = b[6:0];
				end
				default: ;
			endcase
		end
		seq_prev_sel     = sel;
		o.blend_count    = seq_blend;
		o.phase          = seq_phase;
		o.profile_select = sel;
		return o;
	endfunction

	// Mostly no pause, sometimes a short one, now and then a long one.
	function automatic int idle_span();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(4, 24);
	endfunction

	function automatic int pick_channel(bit high_side);
		int r;
		r = $urandom_range(0, 19);
		if (r == 0)
			return high_side ? 201 : 200;
		else if (high_side)
			return $urandom_range(201, 2047);
		else
			return int'($urandom_range(0, 2248)) - 2048;
	endfunction

	task automatic report_mismatch(input string msg);
		errors++;
		if (errors <= SHOWN_ERRORS)
			$display("mismatch at %0t ns: %s", $time, msg);
	endtask

	task automatic send_pass(input int ticks, input int ch);
		in_t beat;
		int  pause;
		pause = steady_source ? 0 : idle_span();
		if (pause != 0) begin
			item_valid <= 1'b0;
			repeat (pause) @(posedge clk);
		end
		beat.elapsed_ticks = ticks[7:0];
		beat.mode_channel  = ch[11:0];
		item_valid <= 1'b1;
		item       <= beat;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		predicted_blends.push_back(advance_sequencer(beat.elapsed_ticks, beat.mode_channel));
		passes_sent++;
	endtask

	task automatic drain_results();
		item_valid <= 1'b0;
		do
			@(posedge clk);
		while (predicted_blends.size() != 0);
	endtask

	task automatic write_speed(input int speed);
		drain_results();
		cfg_valid <= 1'b1;
		cfg_data  <= speed[3:0];
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid     <= 1'b0;
		speed_setting = speed[3:0];
		speed_writes++;
	endtask

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			results_checked++;
			if (predicted_blends.size() == 0) begin
				report_mismatch("result beat arrived with no pass outstanding");
			end else begin
				out_t want;
				want = predicted_blends.pop_front();
				if (result.blend_count !== want.blend_count)
					report_mismatch($sformatf("blend_count got %0d, wanted %0d",
						result.blend_count, want.blend_count));
				if (result.phase !== want.phase)
					report_mismatch($sformatf("phase got %0d, wanted %0d",
						result.phase, want.phase));
				if (result.profile_select !== want.profile_select)
					report_mismatch($sformatf("profile_select got %0b, wanted %0b",
						result.profile_select, want.profile_select));
			end
		end
	end

	always @(posedge clk) begin
		if (stall_left != 0) begin
			result_stall <= 1'b1;
			stall_left = stall_left - 1;
		end else if (steady_sink) begin
			result_stall <= 1'b0;
		end else begin
			stall_left = idle_span();
			result_stall <= (stall_left != 0);
			if (stall_left != 0)
				stall_left = stall_left - 1;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
				(cfg_valid && cfg_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("watchdog: no beat for %0d cycles", quiet_cycles);
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	// Speed left at its reset value: the first pass snaps, then channel steps go upward.
	task automatic test_first_pass();
		send_pass(0, 2047);
		send_pass(255, -2048);
		send_pass(17, 200);
		send_pass(0, 201);
		send_pass(3, 15);
		send_pass(9, -1);
	endtask

	task automatic test_timed_ramps();
		write_speed(15);
		send_pass(255, -2048);
		send_pass(128, 201);
		send_pass(255, 201);
		send_pass(255, 201);
		send_pass(255, 0);
		// Rewriting the same speed must not snap.
		write_speed(15);
		send_pass(1, 201);
		write_speed(1);
		send_pass(255, 201);
		send_pass(255, -7);
		send_pass(255, -7);
		send_pass(255, -7);
	endtask

	// Channel mode keeps whatever direction the last timed ramp latched.
	task automatic test_channel_steps();
		write_speed(0);
		send_pass(40, -7);
		send_pass(40, 9);
		send_pass(40, 100);
		send_pass(0, 2047);
	endtask

	// A steady channel in channel mode never clears the timer, so it wraps; the
	// wrapped count then decides the first timed step.
	task automatic test_timer_wrap();
		int bucket;
		bucket = $urandom_range(0, 255);
		write_speed(0);
		send_pass(0, (bucket << 4) | 5);
		for (int i = 0; i < HOLD_PASSES; i++)
			send_pass($urandom_range(250, 255), (bucket << 4) | $urandom_range(0, 15));
		write_speed(15);
		send_pass(0, (bucket << 4));
		send_pass(255, (bucket << 4));
	endtask

	task automatic test_random_mix();
		int  start;
		int  r;
		int  len;
		int  ch;
		int  ticks;
		bit  side;
		start = passes_sent;
		while (passes_sent - start < RANDOM_PASSES) begin
			r = $urandom_range(0, 19);
			if (r < 6)
				write_speed(1);
			else if (r < 10)
				write_speed(0);
			else if (r < 12)
				write_speed(15);
			else if (r < 14)
				write_speed(2);
			else
				write_speed($urandom_range(1, 15));
			steady_source = ($urandom_range(0, 3) == 0);
			steady_sink   = ($urandom_range(0, 3) == 0);
			r = $urandom_range(0, 9);
			if (r < 5) begin
				// Ramp towards one profile, with the odd reversal part way through.
				side = ($urandom_range(0, 1) == 1);
				len  = $urandom_range(20, 110);
				for (int i = 0; i < len; i++) begin
					if ($urandom_range(0, 49) == 0)
						side = !side;
					ticks = ($urandom_range(0, 9) < 7) ? $urandom_range(150, 255)
						: $urandom_range(0, 255);
					send_pass(ticks, pick_channel(side));
				end
			end else if (r < 8) begin
				// Random walk of the channel, crossing buckets often.
				ch  = int'($urandom_range(0, 4095)) - 2048;
				len = $urandom_range(20, 60);
				for (int i = 0; i < len; i++) begin
					ch = ch + int'($urandom_range(0, 80)) - 40;
					if (ch > 2047)
						ch = 2047;
					if (ch < -2048)
						ch = -2048;
					send_pass($urandom_range(0, 255), ch);
				end
			end else begin
				len = $urandom_range(10, 40);
				for (int i = 0; i < len; i++)
					send_pass($urandom_range(0, 255), $urandom_range(0, 4095));
			end
		end
		steady_source = 1'b0;
		steady_sink   = 1'b0;
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_first_pass();
		test_timed_ramps();
		test_channel_steps();
		test_timer_wrap();
		test_random_mix();
		drain_results();
		repeat (6) @(posedge clk);
		if (predicted_blends.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", predicted_blends.size()));
		$display("Sent %0d control passes across %0d speed settings (timed and channel mode).",
			passes_sent, speed_writes);
		$display("Checked %0d result beats; %0d mismatches.", results_checked, errors);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
